>>> rtl/fpr_pkg.sv
// Shared constants, types and codes of the fingerprint refcount table.
`default_nettype none
package fpr_pkg;
	localparam int ENTRIES  = 1024;
	localparam int KEY_BITS = 64;
	localparam int ADDR_W   = $clog2(ENTRIES);
	localparam int OCC_W    = $clog2(ENTRIES + 1);
	localparam int CNT_W    = 32;
	localparam int USED_W   = OCC_W + 8;
	localparam int CFG_AW   = 4;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_FIND  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] REG_BYTE_BUDGET = 2'd0;
	localparam logic [1:0] REG_ENTRY_BYTES = 2'd1;
	localparam logic [1:0] REG_EVICT_FLOOR = 2'd2;

	typedef enum logic [1:0] {OP_ADD, OP_FIND, OP_CLEAR, OP_NOP} op_t;

	typedef struct packed {
		op_t                 op;
		logic [KEY_BITS-1:0] key;
	} job_t;

	typedef struct packed {
		logic [31:0] byte_budget;
		logic [7:0]  entry_bytes;
		logic [31:0] evict_floor;
	} cfg_t;

	typedef struct packed {
		logic [31:0] ref_count;
		logic        was_present;
		logic [10:0] entries_stored;
		logic [10:0] entries_evicted;
		logic        insert_dropped;
	} res_t;

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_SCAN, ST_DECIDE, ST_EVICT, ST_INSERT, ST_CLEAR, ST_DONE
	} eng_state_t;
endpackage
`default_nettype wire

>>> rtl/fpr_ifs.sv
// Request and result channel interfaces.
`default_nettype none
interface fpr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [63:0] fingerprint_key;
	modport source (output valid, output cmd, output fingerprint_key, input ready);
	modport sink (input valid, input cmd, input fingerprint_key, output ready);
endinterface

interface fpr_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] ref_count;
	logic        was_present;
	logic [10:0] entries_stored;
	logic [10:0] entries_evicted;
	logic        insert_dropped;
	modport source (output valid, output ref_count, output was_present,
		output entries_stored, output entries_evicted, output insert_dropped, input ready);
	modport sink (input valid, input ref_count, input was_present,
		input entries_stored, input entries_evicted, input insert_dropped, output ready);
endinterface
`default_nettype wire

>>> rtl/fpr_cfg.sv
// Configuration registers behind the APB-style port.
`default_nettype none
module fpr_cfg
	import fpr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output cfg_t                   cfg
);
	cfg_t       cfg_q;
	logic       wr;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[CFG_AW-1:2];
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.byte_budget <= 32'd65536;
			cfg_q.entry_bytes <= 8'd48;
			cfg_q.evict_floor <= 32'd1;
		end else if (wr) begin
			case (idx)
				REG_BYTE_BUDGET: cfg_q.byte_budget <= pwdata;
				REG_ENTRY_BYTES: cfg_q.entry_bytes <= pwdata[7:0];
				REG_EVICT_FLOOR: cfg_q.evict_floor <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BYTE_BUDGET: prdata = cfg_q.byte_budget;
			REG_ENTRY_BYTES: prdata = {24'd0, cfg_q.entry_bytes};
			REG_EVICT_FLOOR: prdata = cfg_q.evict_floor;
			default:         prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/fpr_front.sv
// Front end: takes requests, decodes the command and queues jobs for the engine.
`default_nettype none
module fpr_front
	import fpr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	fpr_req_if.sink   req,
	input  wire logic init_done,
	output logic      job_valid,
	input  wire logic job_ready,
	output job_t      job
);
	job_t              q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push, pop;
	job_t              in_job;

	assign req.ready = (cnt_q != QCNT_W'(QDEPTH)) && init_done;
	assign push      = req.valid && req.ready;
	assign job_valid = cnt_q != '0;
	assign pop       = job_valid && job_ready;
	assign job       = q_mem[rd_ptr_q];

	always_comb begin
		in_job.key = req.fingerprint_key[KEY_BITS-1:0];
		case (req.cmd)
			CMD_ADD:   in_job.op = OP_ADD;
			CMD_FIND:  in_job.op = OP_FIND;
			CMD_CLEAR: in_job.op = OP_CLEAR;
			default:   in_job.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= in_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			if (pop)  rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			cnt_q <= QCNT_W'(cnt_q + QCNT_W'(push) - QCNT_W'(pop));
		end
	end
endmodule
`default_nettype wire

>>> rtl/fpr_engine.sv
// Back end: table memories, scan and eviction sequencer, result register.
`default_nettype none
module fpr_engine
	import fpr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic job_valid,
	output logic      job_ready,
	input  wire job_t job,
	output logic      init_done,
	fpr_rsp_if.source rsp
);
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(ENTRIES - 1);

	logic [KEY_BITS-1:0] key_mem [ENTRIES];
	logic [CNT_W-1:0]    cnt_mem [ENTRIES];
	logic                vld_mem [ENTRIES];

	eng_state_t          state_q, state_d;
	logic [ADDR_W-1:0]   addr_q, rd_addr_s1;
	logic                iss_done_q, p_s1;
	logic [KEY_BITS-1:0] key_rd_s1;
	logic [CNT_W-1:0]    cnt_rd_s1;
	logic                vld_rd_s1;
	job_t                job_q;
	logic [OCC_W-1:0]    occ_q, gone_q, occ_new;
	logic                hit_q, free_q, below_q;
	logic [ADDR_W-1:0]   hit_slot_q, free_slot_q;
	logic [CNT_W-1:0]    hit_cnt_q, min_q, sat_inc;
	logic [CNT_W:0]      thr_q;
	res_t                res_q, out_q;
	logic                out_valid_q, out_take;

	logic                issue, last_addr, last_proc, over, evict_hit;
	logic [USED_W-1:0]   used;

	logic                key_we, cnt_we, vld_we;
	logic [ADDR_W-1:0]   key_wa, cnt_wa, vld_wa;
	logic [KEY_BITS-1:0] key_wd;
	logic [CNT_W-1:0]    cnt_wd;
	logic                vld_wd;

	assign last_addr = addr_q == LAST;
	assign last_proc = p_s1 && (rd_addr_s1 == LAST);
	assign used      = USED_W'(occ_q) * USED_W'(cfg.entry_bytes);
	assign over      = (USED_W + CNT_W)'(used) > (USED_W + CNT_W)'(cfg.byte_budget);
	assign sat_inc   = (hit_cnt_q == '1) ? hit_cnt_q : CNT_W'(hit_cnt_q + 1'b1);
	assign evict_hit = vld_rd_s1 && ({1'b0, cnt_rd_s1} < thr_q);
	assign occ_new   = OCC_W'(occ_q - gone_q + OCC_W'(free_q));
	assign out_take  = !out_valid_q || rsp.ready;
	assign job_ready = state_q == ST_IDLE;
	assign init_done = state_q != ST_INIT;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT:   if (last_addr) state_d = ST_IDLE;
			ST_IDLE: begin
				if (job_valid) begin
					case (job.op)
						OP_ADD, OP_FIND: state_d = ST_SCAN;
						OP_CLEAR:        state_d = ST_CLEAR;
						default:         state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN:   if (last_proc) state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (job_q.op == OP_ADD && !hit_q) begin
					state_d = (occ_q != '0 && over) ? ST_EVICT : ST_INSERT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_EVICT:  if (last_proc) state_d = ST_INSERT;
			ST_INSERT: state_d = ST_DONE;
			ST_CLEAR:  if (last_addr) state_d = ST_DONE;
			ST_DONE:   if (out_take) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		issue  = (state_q == ST_SCAN || state_q == ST_EVICT) && !iss_done_q;
		key_we = 1'b0;
		cnt_we = 1'b0;
		vld_we = 1'b0;
		key_wa = free_slot_q;
		cnt_wa = free_slot_q;
		vld_wa = addr_q;
		key_wd = job_q.key;
		cnt_wd = CNT_W'(1);
		vld_wd = 1'b0;
		case (state_q)
			ST_INIT, ST_CLEAR: vld_we = 1'b1;
			ST_EVICT: begin
				vld_we = p_s1 && evict_hit;
				vld_wa = rd_addr_s1;
			end
			ST_DECIDE: begin
				cnt_we = job_q.op == OP_ADD && hit_q;
				cnt_wa = hit_slot_q;
				cnt_wd = sat_inc;
			end
			ST_INSERT: begin
				key_we = free_q;
				cnt_we = free_q;
				vld_we = free_q;
				vld_wa = free_slot_q;
				vld_wd = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) key_mem[key_wa] <= key_wd;
		key_rd_s1 <= key_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		cnt_rd_s1 <= cnt_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (vld_we) vld_mem[vld_wa] <= vld_wd;
		vld_rd_s1 <= vld_mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			addr_q      <= '0;
			iss_done_q  <= 1'b0;
			p_s1        <= 1'b0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			p_s1    <= issue;
			case (state_q)
				ST_INIT:   addr_q <= ADDR_W'(addr_q + 1'b1);
				ST_CLEAR: begin
					addr_q <= ADDR_W'(addr_q + 1'b1);
					occ_q  <= '0;
				end
				ST_IDLE, ST_DECIDE: begin
					addr_q     <= '0;
					iss_done_q <= 1'b0;
				end
				ST_INSERT: occ_q <= occ_new;
				default: begin
					if (issue) begin
						addr_q <= ADDR_W'(addr_q + 1'b1);
						if (last_addr) iss_done_q <= 1'b1;
					end
				end
			endcase
			if (state_q == ST_DONE && out_take) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= addr_q;
		if (state_q == ST_DONE && out_take) out_q <= res_q;
		case (state_q)
			ST_IDLE: begin
				job_q   <= job;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
				below_q <= 1'b0;
				min_q   <= '1;
				res_q   <= '{ref_count: '0, was_present: 1'b0,
					entries_stored: (job.op == OP_CLEAR) ? 11'd0 : 11'(occ_q),
					entries_evicted: 11'd0, insert_dropped: 1'b0};
			end
			ST_SCAN: begin
				if (p_s1) begin
					if (vld_rd_s1 && key_rd_s1 == job_q.key && !hit_q) begin
						hit_q      <= 1'b1;
						hit_slot_q <= rd_addr_s1;
						hit_cnt_q  <= cnt_rd_s1;
					end
					if (!vld_rd_s1 && !free_q) begin
						free_q      <= 1'b1;
						free_slot_q <= rd_addr_s1;
					end
					if (vld_rd_s1 && cnt_rd_s1 < min_q) min_q <= cnt_rd_s1;
					if (vld_rd_s1 && cnt_rd_s1 < cfg.evict_floor) below_q <= 1'b1;
				end
			end
			ST_DECIDE: begin
				gone_q <= '0;
				thr_q  <= below_q ? {1'b0, cfg.evict_floor}
					: (CNT_W + 1)'(min_q) + (CNT_W + 1)'(1);
				if (state_d == ST_EVICT) free_q <= 1'b0;
				res_q.was_present <= hit_q;
				if (job_q.op == OP_ADD) begin
					res_q.ref_count <= sat_inc;
				end else begin
					res_q.ref_count <= hit_q ? hit_cnt_q : '0;
				end
			end
			ST_EVICT: begin
				if (p_s1) begin
					if (evict_hit) gone_q <= OCC_W'(gone_q + 1'b1);
					if ((evict_hit || !vld_rd_s1) && !free_q) begin
						free_q      <= 1'b1;
						free_slot_q <= rd_addr_s1;
					end
				end
			end
			ST_INSERT: begin
				res_q.ref_count       <= free_q ? 32'd1 : 32'd0;
				res_q.was_present     <= 1'b0;
				res_q.entries_stored  <= 11'(occ_new);
				res_q.entries_evicted <= 11'(gone_q);
				res_q.insert_dropped  <= !free_q;
			end
			default: ;
		endcase
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.ref_count       = out_q.ref_count;
	assign rsp.was_present     = out_q.was_present;
	assign rsp.entries_stored  = out_q.entries_stored;
	assign rsp.entries_evicted = out_q.entries_evicted;
	assign rsp.insert_dropped  = out_q.insert_dropped;
endmodule
`default_nettype wire

>>> rtl/fingerprint_refcount_table_core.sv
// Find, add and clear each sweep the table once; a new-key add over the byte budget
// takes a second pass to evict. The engine works on one request at a time, set by the
// single read port of the table memories swept one entry per cycle.
// Reset: asynchronous, active low; then a clearing pass over all entries with
// requests held off while configuration writes are taken.
`default_nettype none
module fingerprint_refcount_table_core
	import fpr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	fpr_req_if.sink                req,
	fpr_rsp_if.source              rsp,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);
	cfg_t cfg;
	job_t job;
	logic job_valid, job_ready, init_done;

	fpr_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	fpr_front u_front (
		.clk, .arst_n, .req, .init_done, .job_valid, .job_ready, .job
	);

	fpr_engine u_engine (
		.clk, .arst_n, .cfg, .job_valid, .job_ready, .job, .init_done, .rsp
	);
endmodule
`default_nettype wire

>>> rtl/fpr_checker.sv
// Port-level checks on the result channel, bound to the top level.
`default_nettype none
module fpr_checker
	import fpr_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] ref_count,
	input wire logic        was_present,
	input wire logic [10:0] entries_stored,
	input wire logic [10:0] entries_evicted,
	input wire logic        insert_dropped
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(ref_count) && $stable(entries_stored))
		else $error("result changed while stalled");

	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && was_present |-> !insert_dropped && entries_evicted == 11'd0
			&& ref_count != 32'd0)
		else $error("hit reported eviction or drop");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && insert_dropped |-> ref_count == 32'd0 && entries_stored == 11'(ENTRIES))
		else $error("drop without full table");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ref_count != 32'd0 |-> entries_stored != 11'd0)
		else $error("nonzero count with empty table");
endmodule

bind fingerprint_refcount_table_core fpr_checker u_fpr_checker (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.ref_count(rsp.ref_count), .was_present(rsp.was_present),
	.entries_stored(rsp.entries_stored), .entries_evicted(rsp.entries_evicted),
	.insert_dropped(rsp.insert_dropped)
);
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the fingerprint refcount table core.
`timescale 1ns / 1ps
module testbench;
	import fpr_pkg::*;

	localparam int HOLD_CYCLES = 5000;
	localparam int DRAIN_CYCLES = 2 * ENTRIES + 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite, pready;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata, prdata;

	fpr_req_if req_ch();
	fpr_rsp_if rsp_ch();

	fingerprint_refcount_table_core uut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// table model
	logic [63:0] tbl_key [ENTRIES];
	logic [31:0] tbl_count [ENTRIES];
	bit tbl_valid [ENTRIES];
	int unsigned tbl_occ;
	logic [31:0] cur_limit;
	logic [7:0] cur_entry_bytes;
	logic [31:0] cur_threshold;

	job_t pending_reqs[$];
	res_t expected_res[$];
	logic [63:0] key_pool [24];
	int send_idle_pct, recv_stall_pct;
	int hold_kicks, hold_seen, hold_left;
	int fail_count, mismatch_count;

	function automatic int unsigned sweep_below(logic [32:0] lim);
		int unsigned gone;
		gone = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_valid[i] && {1'b0, tbl_count[i]} < lim) begin
				tbl_valid[i] = 0;
				gone++;
			end
		tbl_occ -= gone;
		return gone;
	endfunction

	function automatic int unsigned evict_for_insert();
		logic [63:0] used;
		logic [31:0] least;
		int unsigned gone;
		used = 64'(tbl_occ) * 64'(cur_entry_bytes);
		if (used <= 64'(cur_limit) || tbl_occ == 0)
			return 0;
		gone = sweep_below({1'b0, cur_threshold});
		if (gone != 0)
			return gone;
		least = '1;
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_valid[i] && tbl_count[i] < least)
				least = tbl_count[i];
		return sweep_below({1'b0, least} + 33'd1);
	endfunction

	function automatic int find_slot(logic [63:0] k);
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_valid[i] && tbl_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic res_t table_step(job_t j);
		res_t r;
		int slot;
		int unsigned gone;
		r = '0;
		case (j.op)
			OP_ADD: begin
				slot = find_slot(j.key);
				if (slot >= 0) begin
					if (tbl_count[slot] != '1)
						tbl_count[slot]++;
					r.ref_count = tbl_count[slot];
					r.was_present = 1'b1;
				end else begin
					gone = evict_for_insert();
					r.entries_evicted = gone[10:0];
					slot = -1;
					for (int i = 0; i < ENTRIES; i++)
						if (!tbl_valid[i] && slot < 0)
							slot = i;
					if (slot >= 0) begin
						tbl_valid[slot] = 1;
						tbl_key[slot] = j.key;
						tbl_count[slot] = 32'd1;
						tbl_occ++;
						r.ref_count = 32'd1;
					end else begin
						r.insert_dropped = 1'b1;
					end
				end
			end
			OP_FIND: begin
				slot = find_slot(j.key);
				if (slot >= 0) begin
					r.ref_count = tbl_count[slot];
					r.was_present = 1'b1;
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < ENTRIES; i++)
					tbl_valid[i] = 0;
				tbl_occ = 0;
			end
			default: ;
		endcase
		r.entries_stored = tbl_occ[10:0];
		return r;
	endfunction

	// request driver; predict on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				expected_res.push_back(table_step('{op: op_t'(req_ch.cmd),
					key: req_ch.fingerprint_key}));
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() == 0 || $urandom_range(99) < send_idle_pct) begin
					req_ch.valid <= 1'b0;
				end else begin
					job_t j;
					j = pending_reqs.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.cmd <= j.op;
					req_ch.fingerprint_key <= j.key;
				end
			end
		end
	end

	// result sink with random stall and a long hold-off on request
	always @(posedge clk) begin
		if (hold_seen != hold_kicks) begin
			hold_seen <= hold_kicks;
			hold_left <= HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			res_t got, want;
			got = '{rsp_ch.ref_count, rsp_ch.was_present, rsp_ch.entries_stored,
				rsp_ch.entries_evicted, rsp_ch.insert_dropped};
			if (expected_res.size() == 0) begin
				fail_count++;
				$display("unexpected result: %p", got);
			end else begin
				want = expected_res.pop_front();
				if (got != want) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_AW'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_BYTE_BUDGET: cur_limit = val;
			REG_ENTRY_BYTES: cur_entry_bytes = val[7:0];
			default: cur_threshold = val;
		endcase
	endtask

	task automatic set_budget(logic [31:0] lim, logic [7:0] eb, logic [31:0] thr);
		reg_write(REG_BYTE_BUDGET, lim);
		reg_write(REG_ENTRY_BYTES, {24'd0, eb});
		reg_write(REG_EVICT_FLOOR, thr);
	endtask

	task automatic push_req(op_t op, logic [63:0] k);
		pending_reqs.push_back('{op: op, key: k});
	endtask

	// hold until the table is quiet
	task automatic drain();
		while (pending_reqs.size() != 0 || req_ch.valid || expected_res.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (req_ch.valid || expected_res.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_random(int n);
		int pick;
		logic [63:0] k;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			k = ($urandom_range(99) < 70) ? key_pool[$urandom_range(23)]
				: {$urandom, $urandom};
			if (pick < 58) push_req(OP_ADD, k);
			else if (pick < 94) push_req(OP_FIND, k);
			else if (pick < 97) push_req(OP_CLEAR, k);
			else push_req(OP_NOP, k);
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.cmd = OP_ADD;
		req_ch.fingerprint_key = '0;
		rsp_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_kicks = 0;
		hold_seen = 0;
		hold_left = 0;
		fail_count = 0;
		mismatch_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		tbl_occ = 0;
		for (int i = 0; i < ENTRIES; i++)
			tbl_valid[i] = 0;
		for (int i = 0; i < 24; i++)
			key_pool[i] = {$urandom, $urandom};
		cur_limit = 32'd65536;
		cur_entry_bytes = 8'd48;
		cur_threshold = 32'd1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: lookups, repeats, extreme keys, unused command, clear
		set_budget(32'd65536, 8'd48, 32'd1);
		push_req(OP_FIND, 64'd0);
		push_req(OP_ADD, 64'd0);
		push_req(OP_ADD, 64'd0);
		push_req(OP_FIND, 64'd0);
		push_req(OP_ADD, '1);
		push_req(OP_FIND, '1);
		push_req(OP_NOP, '1);
		push_req(OP_CLEAR, '1);
		push_req(OP_FIND, '1);
		drain();

		// tight budget: sweep below threshold, then lowered threshold
		set_budget(32'd100, 8'd50, 32'd2);
		push_req(OP_ADD, 64'h11);
		push_req(OP_ADD, 64'h11);
		push_req(OP_ADD, 64'h22);
		push_req(OP_ADD, 64'h33);
		push_req(OP_ADD, 64'h44);
		push_req(OP_ADD, 64'h55);
		push_req(OP_ADD, 64'h66);
		drain();
		reg_write(REG_EVICT_FLOOR, 32'd1);
		push_req(OP_ADD, 64'h77);
		push_req(OP_ADD, 64'h88);
		push_req(OP_FIND, 64'h11);
		push_req(OP_CLEAR, 64'd0);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_budget(32'd300, 8'd25, 32'd2);
				1: set_budget(32'd0, 8'd255, 32'hFFFF_FFFF);
				2: set_budget(32'd500, 8'd0, 32'd0);
				3: set_budget(32'd1000, 8'd200, 32'd0);
				default: set_budget(32'hFFFF_FFFF, 8'd100, 32'd3);
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 81; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 81; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			if (ph == 4)
				set_budget(32'd2000, 8'd100, 32'd3);
			queue_random(112);
			if (ph == 0) begin
				repeat (20) @(posedge clk);
				hold_kicks++;
			end
			drain();
		end

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
